FILE: rtl/canfd_bit_timing_calculator_macros.svh
// ----------------------------------------------------------------------------
// CAN FD bit timing calculator assertion macros
// Shared property forms, sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CANFD_BIT_TIMING_CALCULATOR_MACROS_SVH
`define CANFD_BIT_TIMING_CALCULATOR_MACROS_SVH

// same-cycle implication
`define CBTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbtc assertion failed");

// next-cycle implication
`define CBTC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbtc assertion failed");

`endif

FILE: rtl/cbtc_pkg.sv
// ----------------------------------------------------------------------------
// cbtc_pkg
// Types and constants of the CAN FD bit timing calculator.
// ----------------------------------------------------------------------------
package cbtc_pkg;

	localparam int DIV_W           = 29;
	localparam int MAX_PRESCALER   = 32;
	localparam int MAX_ARB_SEG1    = 256;
	localparam int MAX_ARB_SEG2    = 128;
	localparam int MAX_DATA_SEG1   = 32;
	localparam int MAX_DATA_SEG2   = 16;
	localparam int MIN_SEG1        = 2;
	localparam int MIN_SEG2        = 1;
	localparam int MIN_DATA_TQ     = 4;
	localparam int SP_MIN          = 50;
	localparam int SP_MAX          = 90;
	localparam int FACTOR_MAX      = 10;
	localparam int PCT_DIV         = 100;
	// x / 100 as (x * 41944) >> 22, exact for x below 43690
	localparam int PCT_RECIP       = 41944;
	localparam int PCT_SHIFT       = 22;
	localparam int TDC_RATE_MAX    = 1000000;
	localparam int TRIPLE_RATE_MAX = 125000;
	localparam int PPM_SCALE       = 1000000;
	localparam int CLK_RESET       = 168000000;
	localparam int TOL_RESET       = 1000;

	typedef enum logic {
		CFG_CLOCK = 1'b0,
		CFG_TOL   = 1'b1
	} cfg_index_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PMUL,
		ST_SSTART,
		ST_SDIV,
		ST_SEVAL,
		ST_D1MUL,
		ST_D1FIX,
		ST_A1FIX,
		ST_WMUL1,
		ST_WMUL2,
		ST_CPREP,
		ST_CMUL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic [9:0] s1;
		logic [9:0] s2;
	} seg_pair_t;

	// starting data bit length: min(49, 385 / factor)
	function automatic logic [5:0] start_tq(input logic [3:0] factor);
		logic [5:0] r;
		case (factor)
			4'd8:    r = 6'd48;
			4'd9:    r = 6'd42;
			4'd10:   r = 6'd38;
			default: r = 6'd49;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/cbtc_div.sv
// ----------------------------------------------------------------------------
// cbtc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbtc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cbtc_pkg::div_req_t req,
	output cbtc_pkg::div_rsp_t rsp
);

	localparam int W = cbtc_pkg::DIV_W;

	logic [W-1:0]         quo_q;
	logic [W-1:0]         rem_q;
	logic [W-1:0]         dsr_q;
	logic [$clog2(W)-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [W:0]           rem_sh;
	logic                 fits;

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(W))'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? W'(rem_sh - {1'b0, dsr_q}) : rem_sh[W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

FILE: rtl/canfd_bit_timing_calculator.sv
// ----------------------------------------------------------------------------
// canfd_bit_timing_calculator
// From accept to result: 1 to 47 search passes, each a prescaler multiply
// and a run of the restoring divider, then the segment split and checks.
// One item at a time; the next is taken while a result waits in the output.
// arst_n clears control state and loads clock 168 MHz and tolerance 1000 ppm.
// ----------------------------------------------------------------------------
`include "canfd_bit_timing_calculator_macros.svh"

// ----------------------------------------------------------------------------
// CAN FD bit timing calculator
// Prescaler search over data bit lengths, segment split and checks.
// ----------------------------------------------------------------------------
module canfd_bit_timing_calculator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [28:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// arbitration_rate[19:0], arbitration_sample_pct[26:20],
	// data_rate_factor[30:27], data_sample_pct[37:31]
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// prescaler[5:0], arb_seg1[14:6], arb_seg2[22:15], arb_jump_width[30:23],
	// data_seg1[36:31], data_seg2[41:37], data_jump_width[46:42],
	// delay_offset[56:47], triple_sample[57], rate_close[58], error_mask[75:59]
	output logic [79:0] m_axis_tdata
);

	localparam logic [19:0] PPM_VEC = 20'(cbtc_pkg::PPM_SCALE);

	cbtc_pkg::state_t   state_q, state_d;
	cbtc_pkg::div_req_t div_req;
	cbtc_pkg::div_rsp_t div_rsp;

	logic [28:0] clock_q;
	logic [19:0] tol_q;
	logic [19:0] rate_q;
	logic [6:0]  sp_a_q, sp_d_q;
	logic [3:0]  factor_q;
	logic [23:0] drate_q;
	logic [5:0]  tq_q;
	logic [28:0] p_q;
	logic [29:0] best_err_q;
	logic [5:0]  best_brp_q, best_tq_q;
	logic [15:0] x_q;
	logic [8:0]  arb_tq_q;
	logic [9:0]  tdc_q;
	logic [5:0]  d1_q;
	logic [4:0]  d2_q;
	logic [8:0]  a1_q;
	logic [7:0]  a2_q;
	logic [34:0] w_q, diff_q;
	logic [55:0] prod_a_q, prod_b_q;
	logic [4:0]  cnt_q;
	logic        out_valid_q;
	logic [79:0] out_data_q;

	logic [19:0] in_rate;
	logic [6:0]  in_sp_a, in_sp_d;
	logic [3:0]  in_factor;
	logic        in_acc;
	logic        search_go;
	logic [28:0] e_hi;
	logic [29:0] err1, err2;
	logic [5:0]  brp1, brp2;
	logic        upd1, upd2;
	logic [31:0] pct_prod;
	logic [9:0]  quo10;
	logic        triple;
	logic [16:0] mask;
	logic        out_load;

	cbtc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	function automatic cbtc_pkg::seg_pair_t split_bit(input logic [9:0] quo,
		input logic [9:0] tq, input logic [9:0] max1, input logic [9:0] max2);
		logic [9:0] a, t, b, over;
		cbtc_pkg::seg_pair_t r;
		a = (quo > 10'd1) ? quo - 10'd1 : 10'd0;
		if (a > max1) a = max1;
		t = (tq > a) ? tq - a : 10'd0;
		b = (t > 10'd1) ? t - 10'd1 : 10'd0;
		over = b - max2;
		if (b > max2) begin
			a = (a > over) ? a - over : 10'd0;
			b = max2;
		end
		r.s1 = a;
		r.s2 = b;
		return r;
	endfunction

	function automatic logic [6:0] clamp_sp(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (v < 7'(cbtc_pkg::SP_MIN)) r = 7'(cbtc_pkg::SP_MIN);
		if (v > 7'(cbtc_pkg::SP_MAX)) r = 7'(cbtc_pkg::SP_MAX);
		return r;
	endfunction

	assign in_rate   = (s_axis_tdata[19:0] == '0) ? 20'd1 : s_axis_tdata[19:0];
	assign in_sp_a   = clamp_sp(s_axis_tdata[26:20]);
	assign in_sp_d   = clamp_sp(s_axis_tdata[37:31]);
	assign in_factor = (s_axis_tdata[30:27] == '0) ? 4'd1 :
		(s_axis_tdata[30:27] > 4'(cbtc_pkg::FACTOR_MAX)) ? 4'(cbtc_pkg::FACTOR_MAX) :
		s_axis_tdata[30:27];
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// percent scaling by reciprocal multiply
	assign pct_prod = 32'(x_q) * 32'(cbtc_pkg::PCT_RECIP);
	assign quo10    = pct_prod[cbtc_pkg::PCT_SHIFT +: 10];

	// search step: floor prescaler then floor + 1
	assign search_go = (best_err_q != '0) && (tq_q >= 6'(cbtc_pkg::MIN_DATA_TQ)) &&
		(div_rsp.quotient <= 29'(cbtc_pkg::MAX_PRESCALER));
	assign e_hi = p_q - div_rsp.remainder;
	assign upd1 = (div_rsp.quotient != '0) && ({1'b0, div_rsp.remainder} < best_err_q);
	assign err1 = upd1 ? {1'b0, div_rsp.remainder} : best_err_q;
	assign brp1 = upd1 ? div_rsp.quotient[5:0] : best_brp_q;
	assign upd2 = (div_rsp.quotient < 29'(cbtc_pkg::MAX_PRESCALER)) &&
		({1'b0, e_hi} < err1);
	assign err2 = upd2 ? {1'b0, e_hi} : err1;
	assign brp2 = upd2 ? div_rsp.quotient[5:0] + 6'd1 : brp1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cbtc_pkg::ST_IDLE:    if (in_acc) state_d = cbtc_pkg::ST_PMUL;
			cbtc_pkg::ST_PMUL:    state_d = cbtc_pkg::ST_SSTART;
			cbtc_pkg::ST_SSTART:  state_d = cbtc_pkg::ST_SDIV;
			cbtc_pkg::ST_SDIV:    if (div_rsp.done) state_d = cbtc_pkg::ST_SEVAL;
			cbtc_pkg::ST_SEVAL:   state_d = search_go ? cbtc_pkg::ST_PMUL : cbtc_pkg::ST_D1MUL;
			cbtc_pkg::ST_D1MUL:   state_d = cbtc_pkg::ST_D1FIX;
			cbtc_pkg::ST_D1FIX:   state_d = cbtc_pkg::ST_A1FIX;
			cbtc_pkg::ST_A1FIX:   state_d = cbtc_pkg::ST_WMUL1;
			cbtc_pkg::ST_WMUL1:   state_d = cbtc_pkg::ST_WMUL2;
			cbtc_pkg::ST_WMUL2:   state_d = cbtc_pkg::ST_CPREP;
			cbtc_pkg::ST_CPREP:   state_d = cbtc_pkg::ST_CMUL;
			cbtc_pkg::ST_CMUL:    if (cnt_q == '0) state_d = cbtc_pkg::ST_FIN;
			cbtc_pkg::ST_FIN:     if (out_load) state_d = cbtc_pkg::ST_IDLE;
			default:              state_d = cbtc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready    = (state_q == cbtc_pkg::ST_IDLE);
		out_load         = (state_q == cbtc_pkg::ST_FIN) && (!out_valid_q || m_axis_tready);
		div_req.start    = (state_q == cbtc_pkg::ST_SSTART);
		div_req.dividend = clock_q;
		div_req.divisor  = p_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbtc_pkg::ST_IDLE;
			clock_q     <= 29'(cbtc_pkg::CLK_RESET);
			tol_q       <= 20'(cbtc_pkg::TOL_RESET);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cbtc_pkg::CFG_CLOCK: clock_q <= cfg_data;
					cbtc_pkg::CFG_TOL:   tol_q   <= cfg_data[19:0];
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cbtc_pkg::ST_IDLE: begin
				rate_q     <= in_rate;
				sp_a_q     <= in_sp_a;
				sp_d_q     <= in_sp_d;
				factor_q   <= in_factor;
				drate_q    <= 24'(in_rate) * 24'(in_factor);
				tq_q       <= cbtc_pkg::start_tq(in_factor);
				best_tq_q  <= cbtc_pkg::start_tq(in_factor);
				best_err_q <= '1;
				best_brp_q <= 6'(cbtc_pkg::MAX_PRESCALER);
			end
			cbtc_pkg::ST_PMUL: p_q <= 29'(30'(drate_q) * 30'(tq_q));
			cbtc_pkg::ST_SEVAL: begin
				if (search_go) begin
					best_err_q <= err2;
					best_brp_q <= brp2;
					if (upd1 || upd2) best_tq_q <= tq_q;
					tq_q <= tq_q - 6'd1;
				end
			end
			cbtc_pkg::ST_D1MUL: begin
				x_q      <= 16'(sp_d_q) * 16'(best_tq_q);
				arb_tq_q <= 9'(10'(best_tq_q) * 10'(factor_q));
				if (drate_q > 24'(cbtc_pkg::TDC_RATE_MAX)) begin
					tdc_q <= 10'((11'(best_brp_q) * 11'(best_tq_q)) >> 1);
				end else begin
					tdc_q <= '0;
				end
			end
			cbtc_pkg::ST_D1FIX: begin
				d1_q <= split_bit(quo10, 10'(best_tq_q), 10'(cbtc_pkg::MAX_DATA_SEG1),
					10'(cbtc_pkg::MAX_DATA_SEG2)).s1[5:0];
				d2_q <= split_bit(quo10, 10'(best_tq_q), 10'(cbtc_pkg::MAX_DATA_SEG1),
					10'(cbtc_pkg::MAX_DATA_SEG2)).s2[4:0];
				x_q  <= 16'(sp_a_q) * 16'(arb_tq_q);
			end
			cbtc_pkg::ST_A1FIX: begin
				a1_q <= split_bit(quo10, 10'(arb_tq_q), 10'(cbtc_pkg::MAX_ARB_SEG1),
					10'(cbtc_pkg::MAX_ARB_SEG2)).s1[8:0];
				a2_q <= split_bit(quo10, 10'(arb_tq_q), 10'(cbtc_pkg::MAX_ARB_SEG1),
					10'(cbtc_pkg::MAX_ARB_SEG2)).s2[7:0];
			end
			cbtc_pkg::ST_WMUL1: w_q <= 35'(29'(arb_tq_q) * 29'(rate_q));
			cbtc_pkg::ST_WMUL2: w_q <= 35'(w_q[28:0]) * 35'(best_brp_q);
			cbtc_pkg::ST_CPREP: begin
				diff_q   <= (35'(clock_q) > w_q) ? 35'(clock_q) - w_q : w_q - 35'(clock_q);
				prod_a_q <= '0;
				prod_b_q <= '0;
				cnt_q    <= 5'd19;
			end
			cbtc_pkg::ST_CMUL: begin
				// msb-first shift-add: w * tolerance and diff * 1e6
				prod_a_q <= {prod_a_q[54:0], 1'b0} + (tol_q[cnt_q] ? 56'(w_q) : 56'd0);
				prod_b_q <= {prod_b_q[54:0], 1'b0} + (PPM_VEC[cnt_q] ? 56'(diff_q) : 56'd0);
				cnt_q    <= cnt_q - 5'd1;
			end
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= {4'd0, mask, prod_b_q <= prod_a_q, triple, tdc_q, d2_q, d2_q,
				d1_q, a2_q, a2_q, a1_q, best_brp_q};
		end
	end

	assign triple = (rate_q <= 20'(cbtc_pkg::TRIPLE_RATE_MAX)) &&
		(a1_q >= 9'(cbtc_pkg::MIN_SEG1));

	always_comb begin
		mask     = '0;
		mask[0]  = (best_brp_q == '0);
		mask[1]  = (best_brp_q != '0) && (best_brp_q > 6'(cbtc_pkg::MAX_PRESCALER));
		mask[2]  = (a1_q < 9'(cbtc_pkg::MIN_SEG1));
		mask[3]  = !mask[2] && (10'(a1_q) > 10'(cbtc_pkg::MAX_ARB_SEG1));
		mask[4]  = (a2_q < 8'(cbtc_pkg::MIN_SEG2));
		mask[5]  = (9'(a2_q) > 9'(cbtc_pkg::MAX_ARB_SEG2));
		mask[6]  = (a2_q == '0);
		mask[7]  = mask[5];
		mask[10] = (d1_q < 6'(cbtc_pkg::MIN_SEG1));
		mask[11] = (7'(d1_q) > 7'(cbtc_pkg::MAX_DATA_SEG1));
		mask[12] = (d2_q < 5'(cbtc_pkg::MIN_SEG2));
		mask[13] = (6'(d2_q) > 6'(cbtc_pkg::MAX_DATA_SEG2));
		mask[14] = (d2_q == '0);
		mask[15] = mask[13];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`CBTC_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_q != cbtc_pkg::ST_IDLE)
	`CBTC_ASSERT_IMP(a_div_done_waited, div_rsp.done, state_q == cbtc_pkg::ST_SDIV)
	`CBTC_ASSERT_IMP(a_brp_range, state_q == cbtc_pkg::ST_D1MUL,
		best_brp_q != '0 && best_brp_q <= 6'(cbtc_pkg::MAX_PRESCALER))
	`CBTC_ASSERT_IMP(a_tq_floor, state_q == cbtc_pkg::ST_SEVAL,
		tq_q >= 6'(cbtc_pkg::MIN_DATA_TQ - 1))

endmodule

FILE: tb/canfd_bit_timing_calculator_check.sv
// ----------------------------------------------------------------------------
// CAN FD bit timing calculator checker
// Watches the config, request and result channels, predicts each timing
// result from the accepted request and the current registers, and compares
// results in order against the predicted ones.
// ----------------------------------------------------------------------------
module canfd_bit_timing_calculator_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [28:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [79:0] m_axis_tdata,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint unsigned u64;

	typedef struct packed {
		logic [16:0] error_mask;
		logic        rate_close;
		logic        triple_sample;
		logic [9:0]  delay_offset;
		logic [4:0]  data_jump_width;
		logic [4:0]  data_seg2;
		logic [5:0]  data_seg1;
		logic [7:0]  arb_jump_width;
		logic [7:0]  arb_seg2;
		logic [8:0]  arb_seg1;
		logic [5:0]  prescaler;
	} timing_t;

	u64 clock_hz;
	u64 tol_ppm;
	timing_t timing_q[$];

	function automatic u64 sub0(u64 a, u64 b);
		return (a > b) ? a - b : 0;
	endfunction

	function automatic u64 clip(u64 v, u64 lo, u64 hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic u64 floor_prescaler(u64 rate, u64 tq, u64 clk_hz);
		u64 d;
		d = rate * tq;
		if (d == 0) return cbtc_pkg::MAX_PRESCALER + 1;
		return clk_hz / d;
	endfunction

	function automatic void split_segments(input u64 tq, input u64 sp, input u64 max1,
		input u64 max2, output u64 s1, output u64 s2);
		u64 a, b;
		a = sub0((sp * tq) / cbtc_pkg::PCT_DIV, 1);
		if (a > max1) a = max1;
		b = sub0(sub0(tq, a), 1);
		if (b > max2) begin
			a = sub0(a, b - max2);
			b = max2;
		end
		s1 = a;
		s2 = b;
	endfunction

	function automatic logic [16:0] range_flag(u64 v, u64 lo, u64 hi, int lo_bit, int hi_bit);
		logic [16:0] m;
		m = '0;
		if (v < lo) m[lo_bit] = 1'b1;
		else if (v > hi) m[hi_bit] = 1'b1;
		return m;
	endfunction

	function automatic timing_t predict_timing(logic [39:0] req);
		u64 rate, sp_a, factor, sp_d, drate, tq, brp, best_err, best_brp, best_tq;
		u64 p, e, d1, d2, a1, a2, tdc, arb_tq, w, diff;
		logic triple;
		logic [16:0] m;
		timing_t r;
		rate = req[19:0];
		sp_a = clip(req[26:20], cbtc_pkg::SP_MIN, cbtc_pkg::SP_MAX);
		factor = clip(req[30:27], 1, cbtc_pkg::FACTOR_MAX);
		sp_d = clip(req[37:31], cbtc_pkg::SP_MIN, cbtc_pkg::SP_MAX);
		if (rate == 0) rate = 1;
		drate = rate * factor;
		tq = (1 + cbtc_pkg::MAX_ARB_SEG1 + cbtc_pkg::MAX_ARB_SEG2) / factor;
		if (tq > 1 + cbtc_pkg::MAX_DATA_SEG1 + cbtc_pkg::MAX_DATA_SEG2)
			tq = 1 + cbtc_pkg::MAX_DATA_SEG1 + cbtc_pkg::MAX_DATA_SEG2;
		best_err = '1;
		best_brp = cbtc_pkg::MAX_PRESCALER;
		best_tq = tq;
		brp = floor_prescaler(drate, tq, clock_hz);
		while (best_err > 0 && tq >= cbtc_pkg::MIN_DATA_TQ && brp <= cbtc_pkg::MAX_PRESCALER)
		begin
			p = drate * tq;
			if (brp > 0) begin
				e = clock_hz - p * brp;
				if (e < best_err) begin
					best_err = e; best_brp = brp; best_tq = tq;
				end
			end
			if (brp < cbtc_pkg::MAX_PRESCALER) begin
				e = p * (brp + 1) - clock_hz;
				if (e < best_err) begin
					best_err = e; best_brp = brp + 1; best_tq = tq;
				end
			end
			tq = tq - 1;
			brp = floor_prescaler(drate, tq, clock_hz);
		end
		split_segments(best_tq, sp_d, cbtc_pkg::MAX_DATA_SEG1, cbtc_pkg::MAX_DATA_SEG2, d1, d2);
		tdc = (drate <= cbtc_pkg::TDC_RATE_MAX) ? 0 : (best_brp * best_tq) / 2;
		if (tdc > 1023) tdc = 1023;
		arb_tq = best_tq * factor;
		split_segments(arb_tq, sp_a, cbtc_pkg::MAX_ARB_SEG1, cbtc_pkg::MAX_ARB_SEG2, a1, a2);
		triple = (rate <= cbtc_pkg::TRIPLE_RATE_MAX) && (a1 >= cbtc_pkg::MIN_SEG1);
		w = arb_tq * rate * best_brp;
		diff = (clock_hz > w) ? clock_hz - w : w - clock_hz;
		m = '0;
		if (best_brp == 0) m[0] = 1'b1;
		else if (best_brp > cbtc_pkg::MAX_PRESCALER) m[1] = 1'b1;
		if (a1 < cbtc_pkg::MIN_SEG1) m[2] = 1'b1;
		else if (a1 > cbtc_pkg::MAX_ARB_SEG1) m[3] = 1'b1;
		m |= range_flag(a2, cbtc_pkg::MIN_SEG2, cbtc_pkg::MAX_ARB_SEG2, 4, 5);
		m |= range_flag(a2, 1, cbtc_pkg::MAX_ARB_SEG2, 6, 7);
		m |= range_flag(d1, cbtc_pkg::MIN_SEG1, cbtc_pkg::MAX_DATA_SEG1, 10, 11);
		m |= range_flag(d2, cbtc_pkg::MIN_SEG2, cbtc_pkg::MAX_DATA_SEG2, 12, 13);
		m |= range_flag(d2, 1, cbtc_pkg::MAX_DATA_SEG2, 14, 15);
		r.prescaler = best_brp[5:0];
		r.arb_seg1 = a1[8:0];
		r.arb_seg2 = a2[7:0];
		r.arb_jump_width = a2[7:0];
		r.data_seg1 = d1[5:0];
		r.data_seg2 = d2[4:0];
		r.data_jump_width = d2[4:0];
		r.delay_offset = tdc[9:0];
		r.triple_sample = triple;
		r.rate_close = (diff * cbtc_pkg::PPM_SCALE) <= (w * tol_ppm);
		r.error_mask = m;
		return r;
	endfunction

	assign pending = timing_q.size();

	initial begin
		fail_count = 0;
		clock_hz = cbtc_pkg::CLK_RESET;
		tol_ppm = cbtc_pkg::TOL_RESET;
	end

	always @(posedge clk) begin
		timing_t got, exp_t;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == cbtc_pkg::CFG_CLOCK) clock_hz = cfg_data;
				else tol_ppm = cfg_data[19:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				timing_q.push_back(predict_timing(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[75:0];
				if (timing_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result %p", got);
				end else begin
					exp_t = timing_q.pop_front();
					if (got !== exp_t || m_axis_tdata[79:76] !== 4'b0) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result mismatch\n  expected %p\n  actual   %p", exp_t, got);
					end
				end
			end
		end
	end

endmodule

FILE: tb/canfd_bit_timing_calculator_test.sv
// ----------------------------------------------------------------------------
// CAN FD bit timing calculator test
// Directed corner requests, then random requests over several clock and
// tolerance settings with random stalls on both sides and one long output
// hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module canfd_bit_timing_calculator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [28:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	int          sent;
	bit          no_stall;
	bit          hold_req;

	canfd_bit_timing_calculator u_dut (.*);
	canfd_bit_timing_calculator_check u_check (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired, %0d results outstanding", pending);
			$display("Mismatches found");
			$finish;
		end
	end

	// result side
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready = 1'b0;
				repeat (3000) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = no_stall ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				m_axis_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic write_reg(input cbtc_pkg::cfg_index_t idx, input logic [28:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_request(input logic [19:0] rate, input logic [6:0] sp_a,
		input logic [3:0] factor, input logic [6:0] sp_d);
		int gap;
		gap = no_stall ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {2'b00, sp_d, factor, sp_a, rate};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		sent++;
	endtask

	task automatic send_random;
		logic [19:0] rate;
		logic [6:0] sp_a, sp_d;
		if ($urandom_range(0, 3) == 0) rate = 20'($urandom);
		else if ($urandom_range(0, 1)) rate = 20'($urandom_range(1, 1000000));
		else rate = 20'($urandom_range(1, 200000));
		sp_a = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(50, 90));
		sp_d = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(50, 90));
		send_request(rate, sp_a, 4'($urandom), sp_d);
	endtask

	task automatic drain;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = cbtc_pkg::CFG_CLOCK;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		idle_cycles = 0;
		sent = 0;
		no_stall = 1'b0;
		hold_req = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed corners at reset settings
		send_request(20'd500000, 7'd80, 4'd2, 7'd75);
		send_request(20'd1, 7'd50, 4'd1, 7'd50);
		send_request(20'd0, 7'd90, 4'd1, 7'd90);
		send_request(20'd1000000, 7'd90, 4'd10, 7'd90);
		send_request(20'hFFFFF, 7'h7F, 4'hF, 7'h7F);
		send_request(20'd125000, 7'd0, 4'd0, 7'd0);
		send_request(20'd125001, 7'd87, 4'd8, 7'd70);
		send_request(20'd250000, 7'd49, 4'd9, 7'd91);
		send_request(20'd1000000, 7'd80, 4'd1, 7'd80);
		send_request(20'd1000000, 7'd75, 4'd5, 7'd60);
		send_request(20'd10000, 7'd87, 4'd4, 7'd80);
		send_request(20'd100000, 7'd60, 4'd3, 7'd55);
		send_request(20'd333333, 7'd70, 4'd6, 7'd85);
		send_request(20'd50, 7'd65, 4'd7, 7'd66);
		drain();

		write_reg(cbtc_pkg::CFG_CLOCK, 29'd1000000);
		write_reg(cbtc_pkg::CFG_TOL, 29'd0);
		send_request(20'd1000000, 7'd90, 4'd10, 7'd90);
		send_request(20'd1, 7'd50, 4'd1, 7'd50);
		send_request(20'd125000, 7'd80, 4'd2, 7'd80);
		hold_req = 1'b1;
		repeat (50) send_random();
		drain();

		write_reg(cbtc_pkg::CFG_CLOCK, 29'd500000000);
		write_reg(cbtc_pkg::CFG_TOL, 29'd1000000);
		send_request(20'd1, 7'd50, 4'd1, 7'd50);
		no_stall = 1'b1;
		repeat (40) send_random();
		no_stall = 1'b0;
		repeat (30) send_random();
		drain();

		write_reg(cbtc_pkg::CFG_CLOCK, 29'd80000000);
		write_reg(cbtc_pkg::CFG_TOL, 29'd5000);
		repeat (60) send_random();
		drain();

		repeat (4) begin
			write_reg(cbtc_pkg::CFG_CLOCK, 29'($urandom_range(1000000, 500000000)));
			write_reg(cbtc_pkg::CFG_TOL, 29'($urandom_range(0, 1000000)));
			repeat (30) send_random();
			drain();
		end

		repeat (200) @(negedge clk);
		$display("Sent %0d timing requests over eight clock and tolerance settings,", sent);
		$display("with random stalls on both channels and one long output hold-off.");
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
